/* hw/rtl/qlct_pkg.sv */
// shared types and constants for the quadratic level crossing timer
`timescale 1ns / 1ps
`default_nettype none
package qlct_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;

    // configuration register indexes
    localparam int CFG_AW = 2;
    localparam logic [CFG_AW-1:0] CFG_LEVEL    = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_INIT_POS = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_EVENT    = 2'd2;

    // input kinds
    localparam logic OPC_UPDATE = 1'b0;
    localparam logic OPC_FIRE   = 1'b1;

    typedef enum logic [1:0] {
        UOP_MUL,
        UOP_DIV,
        UOP_SQRT
    } unit_op_t;

    typedef struct packed {
        logic     start;
        unit_op_t op;
    } unit_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADV_SQ,
        ST_ADV_LIN,
        ST_ADV_Q,
        ST_SLOPE,
        ST_PRED_D,
        ST_SQ_SLOPE,
        ST_SQ_DA,
        ST_SQRT,
        ST_ROOT1,
        ST_ROOT2,
        ST_PICK,
        ST_OUT
    } state_t;

endpackage
`default_nettype wire

/* hw/rtl/quadratic_level_crossing_timer.sv */
// top level: sequencer and datapath of the quadratic level crossing timer
// The block follows position + slope*t + accel*t^2/2 in signed fixed point
// and reports the time until it next reaches the crossing level.
// Input stream s_*: tuser is the kind (update or fire); tdata carries
// elapsed, new slope and new acceleration. Output stream m_*: one result
// transaction per input transaction, tdata = out value and next time,
// tuser = event fired and never flags.
// Configuration: cfg_we/cfg_addr/cfg_data, for the user to write only while
// the block is idle (the block itself does not enforce this); a write of the
// initial position also loads the position. All multiplies, divides and
// square roots run through one shared iterative unit. An update item in the
// worst case uses three multiplies for the advance, two for the discriminant,
// the root and two divides; a fire item with no sign change uses four
// multiplies; a fire with nothing scheduled goes straight to the output
// state. s_tready is high only in the idle state.
// After reset: position 0, slope 0, accel 0, nothing scheduled.
// The result waits in an output register while m_tready is low; the block
// may take the next input meanwhile but holds its next result until free.
`timescale 1ns / 1ps
`default_nettype none
module quadratic_level_crossing_timer #(
    parameter int VALUE_WIDTH = qlct_pkg::VALUE_WIDTH_DEF,
    parameter int FRAC_BITS   = qlct_pkg::FRAC_BITS_DEF
) (
    input  wire                                        clk,
    input  wire                                        rst_n,
    input  wire                                        s_tvalid,
    output logic                                       s_tready,
    // elapsed, new_slope, new_accel
    input  wire  [((3*VALUE_WIDTH+7)/8)*8-1:0]         s_tdata,
    // opcode
    input  wire  [0:0]                                 s_tuser,
    output logic                                       m_tvalid,
    input  wire                                        m_tready,
    // out_value, next_time
    output logic [((2*VALUE_WIDTH+7)/8)*8-1:0]         m_tdata,
    // event_fired, never
    output logic [1:0]                                 m_tuser,
    input  wire                                        cfg_we,
    input  wire  [qlct_pkg::CFG_AW-1:0]                cfg_addr,
    input  wire  [VALUE_WIDTH-1:0]                     cfg_data
);

    localparam int W    = VALUE_WIDTH;
    localparam int F    = FRAC_BITS;
    localparam int XW   = 3 * W;
    localparam int AW   = XW + 2;
    localparam int SN   = 2 * W + 2;
    localparam int NW   = W + 3;
    localparam int SQ_W = (2 * W - F > 64) ? 64 : 2 * W - F;

    function automatic logic [W-1:0] mag_w(input logic [W-1:0] v);
        mag_w = v[W-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic logic [W-1:0] sat_w(input logic [AW-1:0] v);
        logic ok;
        ok = (&v[AW-1:W-1]) || !(|v[AW-1:W-1]);
        if (ok)
            sat_w = v[W-1:0];
        else if (v[AW-1])
            sat_w = {1'b1, {(W-1){1'b0}}};
        else
            sat_w = {1'b0, {(W-1){1'b1}}};
    endfunction

    function automatic logic [AW-1:0] sx(input logic [W-1:0] v);
        sx = {{(AW-W){v[W-1]}}, v};
    endfunction

    // state
    qlct_pkg::state_t state_reg, state_next;
    logic [W-1:0]  level_reg, level_next;
    logic [W-1:0]  event_reg, event_next;
    logic [W-1:0]  pos_reg, pos_next;
    logic [W-1:0]  slope_reg, slope_next;
    logic [W-1:0]  accel_reg, accel_next;
    logic [W-1:0]  tleft_reg, tleft_next;
    logic          never_reg, never_next;

    // per item working registers
    logic          fired_reg, fired_next;
    logic          fire_reg, fire_next;
    logic          started_reg, started_next;
    logic          lin_reg, lin_next;
    logic [W-1:0]  dt_reg, dt_next;
    logic [W-1:0]  in_slope_reg, in_slope_next;
    logic [W-1:0]  in_accel_reg, in_accel_next;
    logic [SQ_W-1:0] sqm_reg, sqm_next;
    logic [AW-1:0] acc_reg, acc_next;
    logic [W-1:0]  d_reg, d_next;
    logic [W:0]    s_reg, s_next;
    logic [W-1:0]  t1_reg, t1_next;
    logic [W-1:0]  t2_reg, t2_next;
    logic          ok1_reg, ok1_next;
    logic          ok2_reg, ok2_next;

    // output register
    logic          m_valid_reg, m_valid_next;
    logic [W-1:0]  o_value_reg, o_value_next;
    logic [W-1:0]  o_time_reg, o_time_next;
    logic          o_fired_reg, o_fired_next;
    logic          o_never_reg, o_never_next;

    // shared unit
    qlct_pkg::unit_req_t u_req;
    qlct_pkg::unit_rsp_t u_rsp;
    logic [XW-1:0] u_a, u_res;
    logic [W-1:0]  u_b;

    qlct_unit #(
        .W  (W),
        .XW (XW),
        .SN (SN)
    ) u_unit (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (u_req),
        .a     (u_a),
        .b     (u_b),
        .rsp   (u_rsp),
        .res   (u_res)
    );

    // shared datapath terms
    logic [XW-1:0] sh_f, sh_f1, sh_fm1;
    logic [AW-1:0] t_f, t_f1, t_fm1;
    logic [AW-1:0] lin_sum, q_sum, slope_sum, d_sum, disc;
    logic [W-1:0]  slope_mag, accel_mag, d_mag, slope_new;
    logic          sign_change, due, op_done, disc_neg;
    logic [NW-1:0] nu, s_ext, num, num_mag;
    logic [W-1:0]  div_v, q_sat;
    logic          root_ok, q_nz, sq_hi;

    assign sh_f   = u_res >> F;
    assign sh_f1  = u_res >> (F + 1);
    assign sh_fm1 = u_res >> (F - 1);
    assign t_f    = {2'b00, sh_f};
    assign t_f1   = {2'b00, sh_f1};
    assign t_fm1  = {2'b00, sh_fm1};
    assign sq_hi  = |(sh_f >> SQ_W);

    assign slope_mag = mag_w(slope_reg);
    assign accel_mag = mag_w(accel_reg);
    assign d_mag     = mag_w(d_reg);

    assign lin_sum   = sx(pos_reg) + (slope_reg[W-1] ? (~t_f + 1'b1) : t_f);
    assign q_sum     = acc_reg + (accel_reg[W-1] ? (~t_f1 + 1'b1) : t_f1);
    assign slope_sum = sx(slope_reg) + (accel_reg[W-1] ? (~t_f + 1'b1) : t_f);
    assign slope_new = sat_w(slope_sum);
    assign sign_change = (slope_new != '0) && (slope_reg != '0)
                         && (slope_new[W-1] != slope_reg[W-1]);
    assign due       = !never_reg && (tleft_reg == dt_reg);
    assign d_sum     = sx(pos_reg) - sx(level_reg);
    assign disc      = (d_reg[W-1] ^ accel_reg[W-1]) ? (acc_reg + t_fm1) : (acc_reg - t_fm1);
    assign disc_neg  = disc[AW-1];
    assign op_done   = started_reg && u_rsp.done;

    // root numerator: -d for the linear case, -slope -/+ s otherwise
    assign nu    = ~{{(NW-W){slope_reg[W-1]}}, slope_reg} + 1'b1;
    assign s_ext = {2'b00, s_reg};
    always_comb
    begin
        if (lin_reg)
            num = ~{{(NW-W){d_reg[W-1]}}, d_reg} + 1'b1;
        else if (state_reg == qlct_pkg::ST_ROOT2)
            num = nu + s_ext;
        else
            num = nu - s_ext;
    end
    assign div_v   = lin_reg ? slope_reg : accel_reg;
    assign root_ok = (num != '0) && (div_v != '0) && (num[NW-1] == div_v[W-1]);
    assign num_mag = num[NW-1] ? (~num + 1'b1) : num;
    assign q_sat   = (|u_res[XW-1:W]) ? {W{1'b1}} : u_res[W-1:0];
    assign q_nz    = u_res != '0;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            qlct_pkg::ST_IDLE:
                if (s_tvalid)
                begin
                    if (s_tuser[0] == qlct_pkg::OPC_FIRE && never_reg)
                        state_next = qlct_pkg::ST_OUT;
                    else
                        state_next = qlct_pkg::ST_ADV_SQ;
                end
            qlct_pkg::ST_ADV_SQ:
                if (op_done) state_next = qlct_pkg::ST_ADV_LIN;
            qlct_pkg::ST_ADV_LIN:
                if (op_done) state_next = qlct_pkg::ST_ADV_Q;
            qlct_pkg::ST_ADV_Q:
                if (op_done)
                begin
                    if (fire_reg)
                        state_next = qlct_pkg::ST_SLOPE;
                    else if (due)
                        state_next = qlct_pkg::ST_OUT;
                    else
                        state_next = qlct_pkg::ST_PRED_D;
                end
            qlct_pkg::ST_SLOPE:
                if (op_done)
                    state_next = sign_change ? qlct_pkg::ST_PRED_D : qlct_pkg::ST_OUT;
            qlct_pkg::ST_PRED_D:
                state_next = (accel_reg == '0) ? qlct_pkg::ST_ROOT1 : qlct_pkg::ST_SQ_SLOPE;
            qlct_pkg::ST_SQ_SLOPE:
                if (op_done) state_next = qlct_pkg::ST_SQ_DA;
            qlct_pkg::ST_SQ_DA:
                if (op_done)
                    state_next = disc_neg ? qlct_pkg::ST_PICK : qlct_pkg::ST_SQRT;
            qlct_pkg::ST_SQRT:
                if (op_done) state_next = qlct_pkg::ST_ROOT1;
            qlct_pkg::ST_ROOT1:
                if (op_done || (!started_reg && !root_ok))
                    state_next = lin_reg ? qlct_pkg::ST_PICK : qlct_pkg::ST_ROOT2;
            qlct_pkg::ST_ROOT2:
                if (op_done || (!started_reg && !root_ok))
                    state_next = qlct_pkg::ST_PICK;
            qlct_pkg::ST_PICK:
                state_next = qlct_pkg::ST_OUT;
            qlct_pkg::ST_OUT:
                if (!m_valid_reg || m_tready) state_next = qlct_pkg::ST_IDLE;
            default:
                state_next = qlct_pkg::ST_IDLE;
        endcase
    end

    // datapath and unit control
    always_comb
    begin
        level_next    = level_reg;
        event_next    = event_reg;
        pos_next      = pos_reg;
        slope_next    = slope_reg;
        accel_next    = accel_reg;
        tleft_next    = tleft_reg;
        never_next    = never_reg;
        fired_next    = fired_reg;
        fire_next     = fire_reg;
        started_next  = started_reg;
        lin_next      = lin_reg;
        dt_next       = dt_reg;
        in_slope_next = in_slope_reg;
        in_accel_next = in_accel_reg;
        sqm_next      = sqm_reg;
        acc_next      = acc_reg;
        d_next        = d_reg;
        s_next        = s_reg;
        t1_next       = t1_reg;
        t2_next       = t2_reg;
        ok1_next      = ok1_reg;
        ok2_next      = ok2_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        o_value_next  = o_value_reg;
        o_time_next   = o_time_reg;
        o_fired_next  = o_fired_reg;
        o_never_next  = o_never_reg;
        u_req.start   = 1'b0;
        u_req.op      = qlct_pkg::UOP_MUL;
        u_a           = '0;
        u_b           = '0;

        unique case (state_reg)
            qlct_pkg::ST_IDLE:
                if (s_tvalid)
                begin
                    fire_next     = (s_tuser[0] == qlct_pkg::OPC_FIRE);
                    fired_next    = (s_tuser[0] == qlct_pkg::OPC_FIRE) && !never_reg;
                    dt_next       = (s_tuser[0] == qlct_pkg::OPC_FIRE) ? tleft_reg : s_tdata[W-1:0];
                    in_slope_next = s_tdata[2*W-1:W];
                    in_accel_next = s_tdata[3*W-1:2*W];
                end
            qlct_pkg::ST_ADV_SQ:
            begin
                u_req.op = qlct_pkg::UOP_MUL;
                u_a      = {{(XW-W){1'b0}}, dt_reg};
                u_b      = dt_reg;
                if (op_done)
                    sqm_next = sq_hi ? {SQ_W{1'b1}} : sh_f[SQ_W-1:0];
            end
            qlct_pkg::ST_ADV_LIN:
            begin
                u_req.op = qlct_pkg::UOP_MUL;
                u_a      = {{(XW-W){1'b0}}, dt_reg};
                u_b      = slope_mag;
                if (op_done)
                    acc_next = lin_sum;
            end
            qlct_pkg::ST_ADV_Q:
            begin
                u_req.op = qlct_pkg::UOP_MUL;
                u_a      = {{(XW-SQ_W){1'b0}}, sqm_reg};
                u_b      = accel_mag;
                if (op_done)
                begin
                    pos_next = sat_w(q_sum);
                    if (!fire_reg)
                    begin
                        slope_next = in_slope_reg;
                        accel_next = in_accel_reg;
                        // update lands on the due time: fire now
                        if (due)
                            tleft_next = '0;
                    end
                end
            end
            qlct_pkg::ST_SLOPE:
            begin
                u_req.op = qlct_pkg::UOP_MUL;
                u_a      = {{(XW-W){1'b0}}, dt_reg};
                u_b      = accel_mag;
                if (op_done)
                begin
                    slope_next = slope_new;
                    if (!sign_change)
                    begin
                        never_next = 1'b1;
                        tleft_next = '0;
                    end
                end
            end
            qlct_pkg::ST_PRED_D:
            begin
                d_next   = sat_w(d_sum);
                lin_next = (accel_reg == '0);
                ok1_next = 1'b0;
                ok2_next = 1'b0;
            end
            qlct_pkg::ST_SQ_SLOPE:
            begin
                u_req.op = qlct_pkg::UOP_MUL;
                u_a      = {{(XW-W){1'b0}}, slope_mag};
                u_b      = slope_mag;
                if (op_done)
                    acc_next = t_f;
            end
            qlct_pkg::ST_SQ_DA:
            begin
                u_req.op = qlct_pkg::UOP_MUL;
                u_a      = {{(XW-W){1'b0}}, d_mag};
                u_b      = accel_mag;
                if (op_done)
                    acc_next = disc;
            end
            qlct_pkg::ST_SQRT:
            begin
                u_req.op = qlct_pkg::UOP_SQRT;
                u_a      = acc_reg[XW-1:0] << F;
                if (op_done)
                    s_next = u_res[W:0];
            end
            qlct_pkg::ST_ROOT1, qlct_pkg::ST_ROOT2:
            begin
                u_req.op = qlct_pkg::UOP_DIV;
                u_a      = {{(XW-NW){1'b0}}, num_mag} << F;
                u_b      = mag_w(div_v);
                if (op_done)
                begin
                    if (state_reg == qlct_pkg::ST_ROOT1)
                    begin
                        ok1_next = q_nz;
                        t1_next  = q_sat;
                    end
                    else
                    begin
                        ok2_next = q_nz;
                        t2_next  = q_sat;
                    end
                end
            end
            qlct_pkg::ST_PICK:
            begin
                if (!ok1_reg && !ok2_reg)
                begin
                    never_next = 1'b1;
                    tleft_next = '0;
                end
                else
                begin
                    never_next = 1'b0;
                    if (ok1_reg && ok2_reg)
                        tleft_next = (t1_reg <= t2_reg) ? t1_reg : t2_reg;
                    else
                        tleft_next = ok1_reg ? t1_reg : t2_reg;
                end
            end
            qlct_pkg::ST_OUT:
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    o_fired_next = fired_reg;
                    o_value_next = fired_reg ? event_reg : '0;
                    o_time_next  = never_reg ? '0 : tleft_reg;
                    o_never_next = never_reg;
                end
            default:
                u_a = '0;
        endcase

        // one launch per arithmetic state, skipped when a root is rejected
        if (state_reg == qlct_pkg::ST_ADV_SQ || state_reg == qlct_pkg::ST_ADV_LIN
            || state_reg == qlct_pkg::ST_ADV_Q || state_reg == qlct_pkg::ST_SLOPE
            || state_reg == qlct_pkg::ST_SQ_SLOPE || state_reg == qlct_pkg::ST_SQ_DA
            || state_reg == qlct_pkg::ST_SQRT || state_reg == qlct_pkg::ST_ROOT1
            || state_reg == qlct_pkg::ST_ROOT2)
        begin
            if (!started_reg)
            begin
                if ((state_reg == qlct_pkg::ST_ROOT1 || state_reg == qlct_pkg::ST_ROOT2)
                    && !root_ok)
                begin
                    u_req.start = 1'b0;
                end
                else
                begin
                    u_req.start  = 1'b1;
                    started_next = 1'b1;
                end
            end
            else if (u_rsp.done)
            begin
                started_next = 1'b0;
            end
        end

        if (cfg_we)
        begin
            priority case (cfg_addr)
                qlct_pkg::CFG_LEVEL:    level_next = cfg_data;
                qlct_pkg::CFG_INIT_POS: pos_next   = cfg_data;
                qlct_pkg::CFG_EVENT:    event_next = cfg_data;
                default:                level_next = level_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= qlct_pkg::ST_IDLE;
            level_reg   <= '0;
            event_reg   <= '0;
            pos_reg     <= '0;
            slope_reg   <= '0;
            accel_reg   <= '0;
            tleft_reg   <= '0;
            never_reg   <= 1'b1;
            started_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            level_reg   <= level_next;
            event_reg   <= event_next;
            pos_reg     <= pos_next;
            slope_reg   <= slope_next;
            accel_reg   <= accel_next;
            tleft_reg   <= tleft_next;
            never_reg   <= never_next;
            started_reg <= started_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fired_reg    <= fired_next;
        fire_reg     <= fire_next;
        lin_reg      <= lin_next;
        dt_reg       <= dt_next;
        in_slope_reg <= in_slope_next;
        in_accel_reg <= in_accel_next;
        sqm_reg      <= sqm_next;
        acc_reg      <= acc_next;
        d_reg        <= d_next;
        s_reg        <= s_next;
        t1_reg       <= t1_next;
        t2_reg       <= t2_next;
        ok1_reg      <= ok1_next;
        ok2_reg      <= ok2_next;
        o_value_reg  <= o_value_next;
        o_time_reg   <= o_time_next;
        o_fired_reg  <= o_fired_next;
        o_never_reg  <= o_never_next;
    end

    assign s_tready = (state_reg == qlct_pkg::ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = {o_never_reg, o_fired_reg};

    always_comb
    begin
        m_tdata          = '0;
        m_tdata[W-1:0]   = o_value_reg;
        m_tdata[2*W-1:W] = o_time_reg;
    end

    // nothing scheduled always means a zero time
    a_never_zero: assert property (@(posedge clk) disable iff (!rst_n)
        never_reg |-> tleft_reg == '0)
        else $error("schedule cleared with nonzero time");

    // the unit finishes only an operation the sequencer is waiting on
    a_done_owned: assert property (@(posedge clk) disable iff (!rst_n)
        u_rsp.done |-> started_reg)
        else $error("unit done without a pending operation");

    // no new launch while the unit is busy
    a_start_free: assert property (@(posedge clk) disable iff (!rst_n)
        u_req.start |-> !u_rsp.busy)
        else $error("unit started while busy");

    // a new result only comes out of the output state
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_valid_reg) |-> $past(state_reg == qlct_pkg::ST_OUT))
        else $error("result loaded outside output state");

endmodule
`default_nettype wire

/* hw/rtl/qlct_unit.sv */
// shared iterative unit: shift-add multiply, restoring divide, digit square root
`timescale 1ns / 1ps
`default_nettype none
module qlct_unit #(
    parameter int W  = qlct_pkg::VALUE_WIDTH_DEF,
    parameter int XW = 3 * qlct_pkg::VALUE_WIDTH_DEF,
    parameter int SN = 2 * qlct_pkg::VALUE_WIDTH_DEF + 2
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire qlct_pkg::unit_req_t req,
    input  wire  [XW-1:0]        a,
    input  wire  [W-1:0]         b,
    output qlct_pkg::unit_rsp_t  rsp,
    output logic [XW-1:0]        res
);

    localparam int RW = W + 3;
    localparam int CW = $clog2(XW + 1);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    qlct_pkg::unit_op_t op_reg, op_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [XW-1:0]      x_reg, x_next;
    logic [W-1:0]       y_reg, y_next;
    logic [XW-1:0]      acc_reg, acc_next;
    logic [RW-1:0]      rem_reg, rem_next;

    logic [XW-1:0] mul_sum;
    logic [W:0]    div_trial, div_diff;
    logic          div_ge;
    logic [RW-1:0] sq_sh, sq_trial, sq_diff;
    logic          sq_ge;

    assign mul_sum   = acc_reg + (y_reg[0] ? x_reg : '0);
    assign div_trial = {rem_reg[W-1:0], x_reg[XW-1]};
    assign div_ge    = div_trial >= {1'b0, y_reg};
    assign div_diff  = div_trial - {1'b0, y_reg};
    assign sq_sh     = {rem_reg[RW-3:0], x_reg[SN-1:SN-2]};
    assign sq_trial  = {acc_reg[W:0], 2'b01};
    assign sq_ge     = sq_sh >= sq_trial;
    assign sq_diff   = sq_sh - sq_trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        if (req.start && !busy_reg)
        begin
            busy_next = 1'b1;
            op_next   = req.op;
            x_next    = a;
            y_next    = b;
            acc_next  = '0;
            rem_next  = '0;
            unique case (req.op)
                qlct_pkg::UOP_MUL:  cnt_next = CW'(W);
                qlct_pkg::UOP_DIV:  cnt_next = CW'(XW);
                qlct_pkg::UOP_SQRT: cnt_next = CW'(SN / 2);
                default:            cnt_next = CW'(1);
            endcase
        end
        else if (busy_reg)
        begin
            unique case (op_reg)
                qlct_pkg::UOP_MUL:
                begin
                    acc_next = mul_sum;
                    x_next   = x_reg << 1;
                    y_next   = y_reg >> 1;
                end
                qlct_pkg::UOP_DIV:
                begin
                    rem_next = {2'b00, (div_ge ? div_diff : div_trial)};
                    acc_next = {acc_reg[XW-2:0], div_ge};
                    x_next   = x_reg << 1;
                end
                qlct_pkg::UOP_SQRT:
                begin
                    rem_next = sq_ge ? sq_diff : sq_sh;
                    acc_next = {acc_reg[XW-2:0], sq_ge};
                    x_next   = x_reg << 2;
                end
                default:
                begin
                    acc_next = acc_reg;
                end
            endcase
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= qlct_pkg::UOP_MUL;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            op_reg   <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        acc_reg <= acc_next;
        rem_reg <= rem_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign res      = acc_reg;

endmodule
`default_nettype wire

/* bench/quadratic_level_crossing_timer_tb.sv */
// self-checking stream testbench for the quadratic level crossing timer
`timescale 1ns / 1ps
module quadratic_level_crossing_timer_tb;

    localparam int W = 32;
    localparam int F = 16;
    localparam int SETTLE = 500;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic signed [127:0] SMAX = 128'sd2147483647;
    localparam logic signed [127:0] SMIN = -128'sd2147483648;

    typedef struct {
        bit          is_cfg;
        logic [1:0]  addr;
        logic [31:0] data;
        logic        op;
        bit          on_due;
        logic [31:0] elapsed;
        logic [31:0] slope;
        logic [31:0] accel;
        int          mode;
    } job_t;

    typedef struct {
        logic        fired;
        logic [31:0] value;
        logic [31:0] next_t;
        logic        never;
    } crossing_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [95:0] s_tdata = '0;
    logic [0:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic [1:0] m_tuser;
    logic cfg_we = 1'b0;
    logic [qlct_pkg::CFG_AW-1:0] cfg_addr = '0;
    logic [W-1:0] cfg_data = '0;

    job_t jobs[$];
    crossing_t pending_crossings[$];
    int presented = 0;
    int taken = 0;
    int settle_cnt = 0;
    int idle_cycles = 0;
    int errors = 0;
    int rx_mode = 0;
    bit stim_done = 0;

    // tracked state of the block
    logic [31:0] trk_level = '0, trk_event = '0;
    logic [31:0] trk_pos = '0, trk_slope = '0, trk_accel = '0, trk_left = '0;
    logic trk_none = 1'b1;

    quadratic_level_crossing_timer DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    function automatic logic signed [127:0] sx(logic [31:0] v);
        return {{96{v[31]}}, v};
    endfunction

    function automatic logic [127:0] mag(logic [31:0] v);
        logic signed [127:0] w;
        w = sx(v);
        return (w < 0) ? -w : w;
    endfunction

    function automatic logic signed [127:0] scaled_product(bit neg, logic [127:0] a,
                                                          logic [127:0] b, int sh);
        logic [127:0] p;
        p = (a * b) >> sh;
        return neg ? -$signed(p) : $signed(p);
    endfunction

    function automatic logic [31:0] sat_signed(logic signed [127:0] w);
        if (w > SMAX) return 32'h7fffffff;
        if (w < SMIN) return 32'h80000000;
        return w[31:0];
    endfunction

    function automatic logic [127:0] floor_sqrt(logic [127:0] n);
        logic [127:0] r, t;
        r = '0;
        for (int i = 63; i >= 0; i--)
        begin
            t = r | (128'd1 << i);
            if (t * t <= n) r = t;
        end
        return r;
    endfunction

    function automatic bit positive_root(logic signed [127:0] num, logic [31:0] div,
                                         output logic [127:0] t);
        logic [127:0] q;
        t = '0;
        if (num == 0 || div == 0 || ((num < 0) != div[31])) return 0;
        q = (((num < 0) ? -num : num) << F) / mag(div);
        if (q == 0) return 0;
        t = q;
        return 1;
    endfunction

    task automatic advance_by(logic [31:0] dt);
        logic [127:0] sq;
        logic signed [127:0] acc;
        sq = ({96'd0, dt} * {96'd0, dt}) >> F;
        acc = sx(trk_pos) + scaled_product(trk_slope[31], {96'd0, dt}, mag(trk_slope), F)
              + scaled_product(trk_accel[31], sq, mag(trk_accel), F + 1);
        trk_pos = sat_signed(acc);
    endtask

    task automatic predict_crossing();
        logic [31:0] d;
        logic [127:0] t1, t2, best, s;
        logic signed [127:0] disc, nu, ss;
        bit ok1, ok2;
        ok1 = 0;
        ok2 = 0;
        d = sat_signed(sx(trk_pos) - sx(trk_level));
        if (trk_accel == 0)
            ok1 = positive_root(-sx(d), trk_slope, t1);
        else
        begin
            disc = $signed((mag(trk_slope) * mag(trk_slope)) >> F)
                   - scaled_product(d[31] ^ trk_accel[31], mag(d), mag(trk_accel), F - 1);
            if (disc >= 0)
            begin
                s = floor_sqrt(disc << F);
                ss = s;
                nu = -sx(trk_slope);
                ok1 = positive_root(nu - ss, trk_accel, t1);
                ok2 = positive_root(nu + ss, trk_accel, t2);
            end
        end
        if (!ok1 && !ok2)
        begin
            trk_none = 1'b1;
            trk_left = '0;
        end
        else
        begin
            if (ok1 && ok2) best = (t1 <= t2) ? t1 : t2;
            else best = ok1 ? t1 : t2;
            trk_left = (best > 128'hffffffff) ? 32'hffffffff : best[31:0];
            trk_none = 1'b0;
        end
    endtask

    task automatic step_crossing(logic op, logic [31:0] e, logic [31:0] sl, logic [31:0] ac,
                                 output crossing_t r);
        logic [31:0] dt, old;
        r.fired = 1'b0;
        if (op == qlct_pkg::OPC_FIRE)
        begin
            if (!trk_none)
            begin
                dt = trk_left;
                old = trk_slope;
                r.fired = 1'b1;
                advance_by(dt);
                trk_slope = sat_signed(sx(trk_slope)
                            + scaled_product(trk_accel[31], {96'd0, dt}, mag(trk_accel), F));
                if (trk_slope != 0 && old != 0 && trk_slope[31] != old[31])
                    predict_crossing();
                else
                begin
                    trk_none = 1'b1;
                    trk_left = '0;
                end
            end
        end
        else
        begin
            advance_by(e);
            trk_slope = sl;
            trk_accel = ac;
            if (!trk_none && trk_left == e) trk_left = '0;
            else predict_crossing();
        end
        r.value = r.fired ? trk_event : '0;
        r.next_t = trk_none ? '0 : trk_left;
        r.never = trk_none;
    endtask

    function automatic int send_idle_pct(int mode);
        return (mode == 0) ? 33 : (mode == 1) ? 87 : 0;
    endfunction

    function automatic int recv_idle_pct(int mode);
        return (mode == 0) ? 87 : (mode == 1) ? 33 : 0;
    endfunction

    // mostly moderate magnitudes so crossings happen, sometimes full range
    function automatic logic [31:0] rand_value(int span_bits);
        if ($urandom_range(9) == 0) return $urandom;
        return $urandom_range((1 << span_bits) - 1) - (1 << (span_bits - 1));
    endfunction

    function automatic job_t cfg_job(logic [1:0] addr, logic [31:0] data);
        job_t j;
        j = '{default: '0};
        j.is_cfg = 1;
        j.addr = addr;
        j.data = data;
        return j;
    endfunction

    function automatic job_t item_job(logic op, logic [31:0] e, logic [31:0] sl,
                                      logic [31:0] ac, bit due, int mode);
        job_t j;
        j = '{default: '0};
        j.op = op;
        j.elapsed = e;
        j.slope = sl;
        j.accel = ac;
        j.on_due = due;
        j.mode = mode;
        return j;
    endfunction

    // driver: inputs change on the falling edge
    always @(negedge clk)
    begin
        logic v, we;
        job_t j;
        v = s_tvalid;
        we = 1'b0;
        if (rst_n && !(s_tvalid && taken != presented))
        begin
            v = 1'b0;
            if (jobs.size() != 0)
            begin
                j = jobs[0];
                if (j.is_cfg)
                begin
                    if (pending_crossings.size() != 0) settle_cnt = 0;
                    else if (settle_cnt < SETTLE) settle_cnt++;
                    else
                    begin
                        we = 1'b1;
                        cfg_addr <= j.addr;
                        cfg_data <= j.data;
                        void'(jobs.pop_front());
                        settle_cnt = 0;
                    end
                end
                else if ($urandom_range(99) >= send_idle_pct(j.mode))
                begin
                    v = 1'b1;
                    s_tuser <= j.op;
                    s_tdata <= {j.accel, j.slope, j.on_due ? trk_left : j.elapsed};
                    presented++;
                    rx_mode <= j.mode;
                    void'(jobs.pop_front());
                end
            end
        end
        s_tvalid <= v;
        cfg_we <= we;
        m_tready <= ($urandom_range(99) >= recv_idle_pct(rx_mode));
    end

    // monitor, predictor and watchdog on the rising edge
    always @(posedge clk)
    begin
        crossing_t r, exp_r;
        logic [31:0] sv, ev;
        if (rst_n)
        begin
            idle_cycles++;
            if (cfg_we)
            begin
                idle_cycles = 0;
                case (cfg_addr)
                    qlct_pkg::CFG_LEVEL: trk_level = cfg_data;
                    qlct_pkg::CFG_INIT_POS: trk_pos = cfg_data;
                    qlct_pkg::CFG_EVENT: trk_event = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                idle_cycles = 0;
                taken++;
                sv = s_tdata[63:32];
                ev = s_tdata[95:64];
                step_crossing(s_tuser[0], s_tdata[31:0], sv, ev, r);
                pending_crossings.push_back(r);
            end
            if (m_tvalid && m_tready)
            begin
                idle_cycles = 0;
                if (pending_crossings.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result transaction tdata=%h tuser=%b",
                             $time, m_tdata, m_tuser);
                end
                else
                begin
                    exp_r = pending_crossings.pop_front();
                    if (m_tuser[0] !== exp_r.fired || m_tdata[31:0] !== exp_r.value ||
                        m_tdata[63:32] !== exp_r.next_t || m_tuser[1] !== exp_r.never)
                    begin
                        errors++;
                        $display("%0t: expected fired=%b value=%h next=%h never=%b",
                                 $time, exp_r.fired, exp_r.value, exp_r.next_t, exp_r.never);
                        $display("%0t:   actual fired=%b value=%h next=%h never=%b",
                                 $time, m_tuser[0], m_tdata[31:0], m_tdata[63:32], m_tuser[1]);
                    end
                end
            end
            if (idle_cycles >= WATCHDOG_LIMIT && !stim_done)
            begin
                $display("%0t: watchdog expired", $time);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial
    begin
        logic [31:0] lvl, pos;
        // directed part
        jobs.push_back(cfg_job(qlct_pkg::CFG_LEVEL, 32'h0001_0000));
        jobs.push_back(cfg_job(qlct_pkg::CFG_INIT_POS, 32'h0));
        jobs.push_back(cfg_job(qlct_pkg::CFG_EVENT, 32'h1234_5678));
        // fire, nothing due
        jobs.push_back(item_job(qlct_pkg::OPC_FIRE, 0, 0, 0, 0, 0));
        // flat, never
        jobs.push_back(item_job(qlct_pkg::OPC_UPDATE, 0, 0, 0, 0, 0));
        // linear root
        jobs.push_back(item_job(qlct_pkg::OPC_UPDATE, 0, 32'h0001_0000, 0, 0, 0));
        jobs.push_back(item_job(qlct_pkg::OPC_FIRE, 0, 0, 0, 0, 0));
        // time saturates
        jobs.push_back(item_job(qlct_pkg::OPC_UPDATE, 0, 32'h1, 0, 0, 0));
        jobs.push_back(item_job(qlct_pkg::OPC_UPDATE, 32'h100, 32'h0002_0000,
                                32'hffff_0000, 0, 0));
        // on due
        jobs.push_back(item_job(qlct_pkg::OPC_UPDATE, 0, 32'h0002_0000, 32'hffff_0000, 1, 0));
        jobs.push_back(item_job(qlct_pkg::OPC_FIRE, 0, 0, 0, 0, 0));
        jobs.push_back(item_job(qlct_pkg::OPC_UPDATE, 32'h0003_0000, 32'h0004_0000,
                                32'hfffc_0000, 0, 0));
        // sign change
        jobs.push_back(item_job(qlct_pkg::OPC_FIRE, 0, 0, 0, 0, 0));
        jobs.push_back(item_job(qlct_pkg::OPC_FIRE, 0, 0, 0, 0, 0));
        // negative disc
        jobs.push_back(item_job(qlct_pkg::OPC_UPDATE, 0, 0, 32'hffff_0000, 0, 0));
        jobs.push_back(item_job(qlct_pkg::OPC_UPDATE, 32'hffff_ffff, 32'h8000_0000,
                                32'h7fff_ffff, 0, 0));
        jobs.push_back(item_job(qlct_pkg::OPC_UPDATE, 32'hffff_ffff, 32'h7fff_ffff,
                                32'h8000_0000, 0, 0));
        jobs.push_back(item_job(qlct_pkg::OPC_UPDATE, 0, 32'h8000_0000, 0, 0, 0));
        jobs.push_back(item_job(qlct_pkg::OPC_FIRE, 0, 0, 0, 0, 0));
        // wide distance
        jobs.push_back(cfg_job(qlct_pkg::CFG_LEVEL, 32'h8000_0000));
        jobs.push_back(cfg_job(qlct_pkg::CFG_INIT_POS, 32'h7fff_ffff));
        jobs.push_back(cfg_job(qlct_pkg::CFG_EVENT, 32'hffff_ffff));
        jobs.push_back(item_job(qlct_pkg::OPC_UPDATE, 0, 32'h7fff_ffff, 32'h0001_0000, 0, 0));
        jobs.push_back(item_job(qlct_pkg::OPC_UPDATE, 0, 32'h8000_0000, 32'h7fff_ffff, 0, 0));
        jobs.push_back(item_job(qlct_pkg::OPC_FIRE, 0, 0, 0, 0, 0));
        jobs.push_back(item_job(qlct_pkg::OPC_UPDATE, 32'h1, 32'h8000_0000,
                                32'h8000_0000, 0, 0));
        jobs.push_back(item_job(qlct_pkg::OPC_FIRE, 0, 0, 0, 0, 0));
        // random part: six settings, two per idle pattern
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: begin lvl = 32'h7fff_ffff; pos = 32'h8000_0000; end
                1: begin lvl = 32'h0; pos = 32'h0; end
                default: begin lvl = rand_value(22); pos = rand_value(22); end
            endcase
            jobs.push_back(cfg_job(qlct_pkg::CFG_LEVEL, lvl));
            jobs.push_back(cfg_job(qlct_pkg::CFG_INIT_POS, pos));
            jobs.push_back(cfg_job(qlct_pkg::CFG_EVENT, (ph == 1) ? 32'h8000_0000 : $urandom));
            for (int i = 0; i < 300; i++)
            begin
                if ($urandom_range(99) < 40)
                    jobs.push_back(item_job(qlct_pkg::OPC_FIRE, $urandom, $urandom, $urandom,
                                            0, ph / 2));
                else
                    jobs.push_back(item_job(qlct_pkg::OPC_UPDATE,
                        ($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h4_0000),
                        rand_value(21), ($urandom_range(4) == 0) ? 32'h0 : rand_value(19),
                        $urandom_range(9) == 0, ph / 2));
            end
        end
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        wait (jobs.size() == 0 && !s_tvalid && pending_crossings.size() == 0);
        stim_done = 1;
        repeat (SETTLE) @(posedge clk);
        if (errors == 0 && pending_crossings.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

/* quadratic_level_crossing_timer.f */
hw/rtl/qlct_pkg.sv
hw/rtl/qlct_unit.sv
hw/rtl/quadratic_level_crossing_timer.sv
bench/quadratic_level_crossing_timer_tb.sv
